// ----- src/vn_pkg.sv -----
// Package for the 3D vector normalizer: widths, pipeline depths and latency.
// No dependencies; used by vector3_normalize.
`default_nettype none
package vn_pkg;
    localparam int W         = 32;           // component and result width
    localparam int SQW       = 2 * W;        // sum of squares width
    localparam int SQ_STEPS  = W;            // root bits, one per stage
    localparam int DIV_STEPS = W - 1;        // quotient bits, one per stage
    localparam int FRAC_OUT  = 30;           // fraction bits of the unit vector
    localparam int LATENCY   = 3 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef logic [W-1:0]   t_word;
    typedef logic [SQW-1:0] t_wide;
    typedef logic [W-2:0]   t_quot;

    // Unit component in two's complement from quotient and sign.
    function automatic t_word apply_sign(input t_quot q, input logic neg);
        t_word m;
        m = {1'b0, q};
        return neg ? (~m + t_word'(1)) : m;
    endfunction
endpackage
`default_nettype wire

// ----- src/vector3_normalize.sv -----
// Vector normalizer top level: length and unit direction of a 3D vector.
// Depends on vn_pkg.
//
// One transaction enters on any cycle that start is high; busy stays low, so a
// new vector can follow every cycle. Each result appears on o_valid for one cycle,
// in input order. The pipeline is the chain: absolute value, three 32x32
// squarers, a 64-bit adder, a 32-stage bit-per-stage square root, a divider
// setup register and three 31-stage bit-per-stage dividers, then the output
// register. A zero vector raises o_zero_vector with all other fields 0.
`default_nettype none
module vector3_normalize (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [31:0]   i_vec_x,
    input  wire logic signed [31:0]   i_vec_y,
    input  wire logic signed [31:0]   i_vec_z,
    output logic                      o_valid,
    output logic signed [31:0]        o_unit_x,
    output logic signed [31:0]        o_unit_y,
    output logic signed [31:0]        o_unit_z,
    output logic [31:0]               o_magnitude,
    output logic                      o_zero_vector
);
    import vn_pkg::*;

    // Valid bits, one per register stage.
    logic [LATENCY-1:0] r_vld;

    // Stage 1: magnitudes and signs.
    t_word      r_abs [3];
    logic [2:0] r_neg1;
    // Stage 2: squares.
    t_wide      r_sq [3];
    t_word      r_abs2 [3];
    logic [2:0] r_neg2;

    // Square root stages: index 0 holds the sum, index i the state after i steps.
    logic [W+1:0] r_sr_rem  [SQ_STEPS+1];
    t_word        r_sr_root [SQ_STEPS+1];
    t_wide        r_sr_n    [SQ_STEPS+1];
    t_word        r_sr_a    [SQ_STEPS+1][3];
    logic [2:0]   r_sr_neg  [SQ_STEPS+1];
    logic         r_sr_zero [SQ_STEPS+1];

    // Divider stages: index 0 is the initial remainder.
    t_word      r_dv_rem [DIV_STEPS+1][3];
    t_quot      r_dv_q   [DIV_STEPS+1][3];
    t_quot      r_dv_nb  [DIV_STEPS+1][3];
    t_word      r_dv_d   [DIV_STEPS+1];
    logic [2:0] r_dv_neg [DIV_STEPS+1];
    logic       r_dv_zero[DIV_STEPS+1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1[0] <= i_vec_x[W-1];
        r_neg1[1] <= i_vec_y[W-1];
        r_neg1[2] <= i_vec_z[W-1];
        r_abs[0]  <= i_vec_x[W-1] ? (~t_word'(i_vec_x) + t_word'(1)) : t_word'(i_vec_x);
        r_abs[1]  <= i_vec_y[W-1] ? (~t_word'(i_vec_y) + t_word'(1)) : t_word'(i_vec_y);
        r_abs[2]  <= i_vec_z[W-1] ? (~t_word'(i_vec_z) + t_word'(1)) : t_word'(i_vec_z);
        for (int k = 0; k < 3; k++) begin
            r_sq[k]   <= t_wide'(r_abs[k]) * t_wide'(r_abs[k]);
            r_abs2[k] <= r_abs[k];
        end
        r_neg2 <= r_neg1;
        r_sr_n[0]    <= r_sq[0] + r_sq[1] + r_sq[2];
        r_sr_zero[0] <= (r_abs2[0] == '0) && (r_abs2[1] == '0) && (r_abs2[2] == '0);
        r_sr_rem[0]  <= '0;
        r_sr_root[0] <= '0;
        r_sr_a[0]    <= r_abs2;
        r_sr_neg[0]  <= r_neg2;
    end

    // One root bit per stage: bring down two bits, try subtracting 4*root+1.
    for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
        logic [W+3:0] n_trial;
        logic [W+3:0] n_sub;
        always_comb begin
            n_trial = {r_sr_rem[i], r_sr_n[i][SQW-1:SQW-2]};
            n_sub   = {2'b00, r_sr_root[i], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (n_trial >= n_sub) begin
                r_sr_rem[i+1]  <= (W+2)'(n_trial - n_sub);
                r_sr_root[i+1] <= {r_sr_root[i][W-2:0], 1'b1};
            end else begin
                r_sr_rem[i+1]  <= (W+2)'(n_trial);
                r_sr_root[i+1] <= {r_sr_root[i][W-2:0], 1'b0};
            end
            r_sr_n[i+1]    <= {r_sr_n[i][SQW-3:0], 2'b00};
            r_sr_a[i+1]    <= r_sr_a[i];
            r_sr_neg[i+1]  <= r_sr_neg[i];
            r_sr_zero[i+1] <= r_sr_zero[i];
        end
    end

    // The quotient of (a << 30) / mag fits in 31 bits because mag >= a, so the
    // top 31 dividend bits already sit below the divisor.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dv_rem[0][k] <= {1'b0, r_sr_a[SQ_STEPS][k][W-1:1]};
            r_dv_nb[0][k]  <= {r_sr_a[SQ_STEPS][k][0], (W-2)'(0)};
            r_dv_q[0][k]   <= '0;
        end
        r_dv_d[0]    <= r_sr_root[SQ_STEPS];
        r_dv_neg[0]  <= r_sr_neg[SQ_STEPS];
        r_dv_zero[0] <= r_sr_zero[SQ_STEPS];
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        for (genvar k = 0; k < 3; k++) begin : g_lane
            logic [W:0] n_part;
            logic [W:0] n_diff;
            always_comb begin
                n_part = {r_dv_rem[j][k], r_dv_nb[j][k][W-2]};
                n_diff = n_part - {1'b0, r_dv_d[j]};
            end
            always_ff @(posedge i_clk) begin
                if (n_part >= {1'b0, r_dv_d[j]}) begin
                    r_dv_rem[j+1][k] <= n_diff[W-1:0];
                    r_dv_q[j+1][k]   <= {r_dv_q[j][k][W-3:0], 1'b1};
                end else begin
                    r_dv_rem[j+1][k] <= n_part[W-1:0];
                    r_dv_q[j+1][k]   <= {r_dv_q[j][k][W-3:0], 1'b0};
                end
                r_dv_nb[j+1][k] <= {r_dv_nb[j][k][W-3:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            r_dv_d[j+1]    <= r_dv_d[j];
            r_dv_neg[j+1]  <= r_dv_neg[j];
            r_dv_zero[j+1] <= r_dv_zero[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv_zero[DIV_STEPS]) begin
            o_unit_x    <= '0;
            o_unit_y    <= '0;
            o_unit_z    <= '0;
            o_magnitude <= '0;
        end else begin
            o_unit_x    <= apply_sign(r_dv_q[DIV_STEPS][0], r_dv_neg[DIV_STEPS][0]);
            o_unit_y    <= apply_sign(r_dv_q[DIV_STEPS][1], r_dv_neg[DIV_STEPS][1]);
            o_unit_z    <= apply_sign(r_dv_q[DIV_STEPS][2], r_dv_neg[DIV_STEPS][2]);
            o_magnitude <= r_dv_d[DIV_STEPS];
        end
        o_zero_vector <= r_dv_zero[DIV_STEPS];
    end

    assign o_valid = r_vld[LATENCY-1];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without a matching start");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> (o_magnitude == '0 && o_unit_x == '0))
        else $error("zero vector with nonzero fields");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x <= (32'sd1 <<< FRAC_OUT) && o_unit_x >= -(32'sd1 <<< FRAC_OUT)))
        else $error("unit component out of range");

    a_nonzero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero_vector) |-> (o_magnitude != '0))
        else $error("nonzero vector with zero magnitude");
endmodule
`default_nettype wire

// ----- test/vector3_normalize_test.sv -----
// Testbench for vector3_normalize: drives vectors in bursts and checks each
// result against a bit-exact predictor of length and unit direction.
// Depends on vn_pkg and vector3_normalize.
`timescale 1ns / 100ps
module vector3_normalize_test;
    import vn_pkg::*;

    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] mag;
        logic        zero;
    } t_norm;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic signed [31:0] i_vec_x = '0;
    logic signed [31:0] i_vec_y = '0;
    logic signed [31:0] i_vec_z = '0;
    logic        o_valid;
    logic signed [31:0] o_unit_x, o_unit_y, o_unit_z;
    logic [31:0] o_magnitude;
    logic        o_zero_vector;

    t_norm       norm_queue[$];
    int          error_count = 0;
    longint      cycle_count = 0;

    vector3_normalize u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vec_x(i_vec_x), .i_vec_y(i_vec_y), .i_vec_z(i_vec_z),
        .o_valid(o_valid), .o_unit_x(o_unit_x), .o_unit_y(o_unit_y),
        .o_unit_z(o_unit_z), .o_magnitude(o_magnitude),
        .o_zero_vector(o_zero_vector)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] abs_word(input logic [31:0] v);
        logic [31:0] a;
        a = v[31] ? (~v + 32'd1) : v;
        return {32'd0, a};
    endfunction

    function automatic logic [63:0] floor_root(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_of(input logic [31:0] v, input logic [63:0] mag);
        logic [63:0] q;
        q = (abs_word(v) << 30) / mag;
        if (v[31]) q = -q;
        return q[31:0];
    endfunction

    function automatic t_norm predict_norm(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
        t_norm r;
        logic [63:0] sum;
        logic [63:0] mag;
        sum = abs_word(x) * abs_word(x) + abs_word(y) * abs_word(y)
            + abs_word(z) * abs_word(z);
        r = '0;
        if (sum == 0) begin
            r.zero = 1'b1;
        end else begin
            mag = floor_root(sum);
            r.ux = unit_of(x, mag);
            r.uy = unit_of(y, mag);
            r.uz = unit_of(z, mag);
            r.mag = mag[31:0];
        end
        return r;
    endfunction

    // Sends one transaction; start stays high unless idle cycles follow it.
    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input int gap);
        start <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        norm_queue.push_back(predict_norm(x, y, z));
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_norm want;
        if (i_rst_n && o_valid) begin
            if (norm_queue.size() == 0) begin
                $display("%0t unexpected result mag=%h", $time, o_magnitude);
                error_count++;
            end else begin
                want = norm_queue.pop_front();
                if (want !== {o_unit_x, o_unit_y, o_unit_z, o_magnitude, o_zero_vector}) begin
                    $display("%0t mismatch expected ux=%h uy=%h uz=%h mag=%h zero=%b",
                             $time, want.ux, want.uy, want.uz, want.mag, want.zero);
                    $display("%0t          actual   ux=%h uy=%h uz=%h mag=%h zero=%b",
                             $time, o_unit_x, o_unit_y, o_unit_z, o_magnitude,
                             o_zero_vector);
                    error_count++;
                end
            end
        end
    end

    task automatic test_extremes();
        logic [31:0] ext[6];
        ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        send_vector(0, 0, 0, 2);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vector(1, 0, 0, 2);
        send_vector(0, 32'hFFFF_FFFF, 0, 0);
        send_vector(0, 0, 32'h8000_0000, 2);
        send_vector(1, 1, 1, 0);
        send_vector(32'h0003_0000, 32'h0004_0000, 0, 2);
        for (int i = 0; i < 12; i++)
            send_vector(ext[$urandom_range(5)], ext[$urandom_range(5)],
                        ext[$urandom_range(5)], i[0] ? 0 : 3);
        send_vector(0, 0, 0, 2);
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(511)) - 256);
            2: return 32'($signed($urandom_range(32'h7_FFFF)) - 32'h4_0000);
            default: return $urandom_range(1) ? 32'h0 : $urandom;
        endcase
    endfunction

    task automatic test_random_bursts();
        int burst;
        int sent;
        sent = 0;
        while (sent < 850) begin
            burst = $urandom_range(40, 1);
            for (int i = 0; i < burst; i++) begin
                send_vector(random_component(), random_component(), random_component(),
                            (i == burst - 1) ? $urandom_range(6) : 0);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_random_bursts();
        start <= 1'b0;
        while (norm_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
src/vn_pkg.sv
src/vector3_normalize.sv
test/vector3_normalize_test.sv
